FILE: design/qcpc_pkg.sv
`timescale 1ns / 1ps

package qcpc_pkg;

  localparam int CordicStagesDef = 24;
  localparam int CordicStagesMax = 32;

  localparam int TagW = 32;
  localparam int LonW = 26;
  localparam int LatW = 24;
  localparam int TolW = 41;

  // regularised longitude, query offsets, products, CORDIC datapath, angle
  localparam int RlonW = 28;
  localparam int DxW   = 29;
  localparam int DyW   = 25;
  localparam int PrW   = DxW + DyW;
  localparam int CdW   = PrW + 1;
  localparam int XW    = CdW + 3;
  localparam int ZW    = 34;
  localparam int SumW  = ZW + 2;
  localparam int LsumW = RlonW + 2;

  localparam logic signed [RlonW-1:0] Deg360 = 28'sd23592960;
  localparam logic signed [RlonW-1:0] Deg270 = 28'sd17694720;
  localparam logic signed [RlonW-1:0] Deg90  = 28'sd5898240;
  localparam logic signed [LsumW-1:0] Deg540 = 30'sd35389440;
  localparam logic signed [LatW-1:0]  LatN   = 24'sd5898240;
  localparam logic signed [LatW-1:0]  LatS   = -24'sd5898240;

  localparam logic signed [ZW-1:0]   HalfPi = 34'sd1686629713;
  localparam logic signed [SumW-1:0] PiFix  = 36'sd3373259426;

  localparam logic [TolW-1:0] TolReset = 41'd1;

  // atan(2^-i) in units of 2^-30 radian
  function automatic logic signed [ZW-1:0] atan_lut(input int i);
    logic signed [ZW-1:0] r;
    case (i)
      0:       r = 34'sd843314857;
      1:       r = 34'sd497837829;
      2:       r = 34'sd263043837;
      3:       r = 34'sd133525159;
      4:       r = 34'sd67021688;
      5:       r = 34'sd33543516;
      6:       r = 34'sd16775851;
      7:       r = 34'sd8388437;
      8:       r = 34'sd4194283;
      9:       r = 34'sd2097149;
      10:      r = 34'sd1048576;
      31:      r = 34'sd1;
      default: r = ZW'(34'sd1 <<< (30 - i));
    endcase
    return r;
  endfunction

endpackage

FILE: design/quad_cell_point_containment_top.sv
`timescale 1ns / 1ps

// channel  | direction | handshake              | payload
// ---------+-----------+------------------------+----------------------------------
// item     | in        | start_i, busy_o        | face_id_i, v0..v3 lon/lat, query
// result   | out       | done_o (one-cycle)     | tag_out_o, inside_res_o, on_vertex_o
// config   | in        | cfg_valid_i/cfg_ready_o| cfg_data_i (tolerance)
//
// One word is taken every cycle; busy_o stays low.
// The pipe has five set-up stages (regularise, pole fix, products,
// cross/dot, pre-rotation), one register per CORDIC vectoring stage, and
// angle sum plus output register. Reset clears all valid bits; tolerance
// resets to 1. The receiver cannot stall, so nothing in the pipe ever waits.

module quad_cell_point_containment_top
  import qcpc_pkg::*;
#(
  parameter int CORDIC_STAGES = CordicStagesDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  output logic                   busy_o,
  input  logic [TagW-1:0]        face_id_i,
  input  logic signed [LonW-1:0] v0_lon_i,
  input  logic signed [LatW-1:0] v0_lat_i,
  input  logic signed [LonW-1:0] v1_lon_i,
  input  logic signed [LatW-1:0] v1_lat_i,
  input  logic signed [LonW-1:0] v2_lon_i,
  input  logic signed [LatW-1:0] v2_lat_i,
  input  logic signed [LonW-1:0] v3_lon_i,
  input  logic signed [LatW-1:0] v3_lat_i,
  input  logic signed [LonW-1:0] query_lon_i,
  input  logic signed [LatW-1:0] query_lat_i,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [TolW-1:0]        cfg_data_i,
  output logic                   done_o,
  output logic [TagW-1:0]        tag_out_o,
  output logic                   inside_res_o,
  output logic                   on_vertex_o
);

  localparam int NPre = 5;
  localparam int NV   = NPre + CORDIC_STAGES + 2;

  logic [TolW-1:0] tol_q;
  logic [NV-1:0]   v_q;
  logic [TagW-1:0] tag_q [NV];

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TolReset;
    end else if (cfg_valid_i) begin
      tol_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[NV-2:0], start_i & ~busy_o};
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q[0] <= face_id_i;
    for (int s = 1; s < NV; s++) tag_q[s] <= tag_q[s-1];
  end

  // stage 1: regularise longitudes against corner 0
  logic signed [LonW-1:0]  lon_in [4];
  logic signed [LatW-1:0]  lat_in [4];
  logic signed [RlonW-1:0] lon1_d [4], lon1_q [4];
  logic signed [LatW-1:0]  lat1_q [4];
  logic signed [LonW-1:0]  qlon1_q, qlon2_q;
  logic signed [LatW-1:0]  qlat1_q, qlat2_q;

  assign lon_in = '{v0_lon_i, v1_lon_i, v2_lon_i, v3_lon_i};
  assign lat_in = '{v0_lat_i, v1_lat_i, v2_lat_i, v3_lat_i};

  always_comb begin
    logic signed [RlonW-1:0] d, add;
    logic [RlonW:0] mn, m0, mp, best;
    logic signed [RlonW:0] t;
    lon1_d[0] = RlonW'(lon_in[0]);
    for (int k = 1; k < 4; k++) begin
      d = RlonW'(lon_in[k]) - RlonW'(lon_in[0]);
      t = (RlonW+1)'(d) - (RlonW+1)'(Deg360);
      mn = t[RlonW] ? (RlonW+1)'(-t) : (RlonW+1)'(t);
      t = (RlonW+1)'(d);
      m0 = t[RlonW] ? (RlonW+1)'(-t) : (RlonW+1)'(t);
      t = (RlonW+1)'(d) + (RlonW+1)'(Deg360);
      mp = t[RlonW] ? (RlonW+1)'(-t) : (RlonW+1)'(t);
      best = mn;
      add = -Deg360;
      if (m0 < best) begin
        best = m0;
        add = '0;
      end
      if (mp < best) begin
        add = Deg360;
      end
      lon1_d[k] = RlonW'(lon_in[k]) + add;
    end
  end

  always_ff @(posedge clk_i) begin
    lon1_q  <= lon1_d;
    lat1_q  <= lat_in;
    qlon1_q <= query_lon_i;
    qlat1_q <= query_lat_i;
  end

  // stage 2: pole corner longitude
  logic signed [RlonW-1:0] lon2_d [4], lon2_q [4];
  logic signed [LatW-1:0]  lat2_q [4];

  always_comb begin
    logic signed [LsumW-1:0] sum;
    logic has_pole;
    logic [1:0] last;
    sum = '0;
    has_pole = 1'b0;
    last = '0;
    for (int k = 0; k < 4; k++) begin
      if (lat1_q[k] == LatN || lat1_q[k] == LatS) begin
        has_pole = 1'b1;
        last = 2'(k);
      end else begin
        sum = sum + LsumW'(lon1_q[k]);
      end
    end
    for (int k = 0; k < 4; k++) begin
      lon2_d[k] = lon1_q[k];
      if (has_pole && last == 2'(k)) lon2_d[k] = (sum > Deg540) ? Deg270 : Deg90;
    end
  end

  always_ff @(posedge clk_i) begin
    lon2_q  <= lon2_d;
    lat2_q  <= lat1_q;
    qlon2_q <= qlon1_q;
    qlat2_q <= qlat1_q;
  end

  // stage 3: products per edge
  logic signed [PrW-1:0] pxy_q [4], pyx_q [4], pxx_q [4], pyy_q [4];

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 4; k++) begin
      pxy_q[k] <= (DxW'(qlon2_q) - DxW'(lon2_q[k])) * (DyW'(qlat2_q) - DyW'(lat2_q[(k+1)%4]));
      pyx_q[k] <= (DyW'(qlat2_q) - DyW'(lat2_q[k])) * (DxW'(qlon2_q) - DxW'(lon2_q[(k+1)%4]));
      pxx_q[k] <= (DxW'(qlon2_q) - DxW'(lon2_q[k])) * (DxW'(qlon2_q) - DxW'(lon2_q[(k+1)%4]));
      pyy_q[k] <= (DyW'(qlat2_q) - DyW'(lat2_q[k])) * (DyW'(qlat2_q) - DyW'(lat2_q[(k+1)%4]));
    end
  end

  // stage 4: cross and dot
  logic signed [CdW-1:0] cr_q [4], dt_q [4];

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 4; k++) begin
      cr_q[k] <= CdW'(pxy_q[k]) - CdW'(pyx_q[k]);
      dt_q[k] <= CdW'(pxx_q[k]) + CdW'(pyy_q[k]);
    end
  end

  // stage 5: on-vertex test and quarter-turn pre-rotation
  logic signed [XW-1:0] cx_q [CORDIC_STAGES+1][4];
  logic signed [XW-1:0] cy_q [CORDIC_STAGES+1][4];
  logic signed [ZW-1:0] cz_q [CORDIC_STAGES+1][4];
  logic [3:0]           zero_q [CORDIC_STAGES+1];
  logic                 vert_q [CORDIC_STAGES+2];

  always_ff @(posedge clk_i) begin
    logic vert;
    logic [CdW-1:0] mc, md;
    logic signed [XW-1:0] x, y;
    vert = 1'b0;
    for (int k = 0; k < 4; k++) begin
      mc = cr_q[k][CdW-1] ? CdW'(-cr_q[k]) : CdW'(cr_q[k]);
      md = dt_q[k][CdW-1] ? CdW'(-dt_q[k]) : CdW'(dt_q[k]);
      if (mc < CdW'(tol_q) && md < CdW'(tol_q)) vert = 1'b1;
      x = XW'(dt_q[k]);
      y = XW'(cr_q[k]);
      zero_q[0][k] <= (x == '0) && (y == '0);
      if (x < 0) begin
        if (y >= 0) begin
          cx_q[0][k] <= y;
          cy_q[0][k] <= -x;
          cz_q[0][k] <= HalfPi;
        end else begin
          cx_q[0][k] <= -y;
          cy_q[0][k] <= x;
          cz_q[0][k] <= -HalfPi;
        end
      end else begin
        cx_q[0][k] <= x;
        cy_q[0][k] <= y;
        cz_q[0][k] <= '0;
      end
    end
    vert_q[0] <= vert;
  end

  // CORDIC vectoring stages, one register each
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    localparam logic signed [ZW-1:0] Ang = atan_lut(i);
    always_ff @(posedge clk_i) begin
      for (int k = 0; k < 4; k++) begin
        if (cy_q[i][k] >= 0) begin
          cx_q[i+1][k] <= cx_q[i][k] + (cy_q[i][k] >>> i);
          cy_q[i+1][k] <= cy_q[i][k] - (cx_q[i][k] >>> i);
          cz_q[i+1][k] <= cz_q[i][k] + Ang;
        end else begin
          cx_q[i+1][k] <= cx_q[i][k] - (cy_q[i][k] >>> i);
          cy_q[i+1][k] <= cy_q[i][k] + (cx_q[i][k] >>> i);
          cz_q[i+1][k] <= cz_q[i][k] - Ang;
        end
      end
      zero_q[i+1] <= zero_q[i];
      vert_q[i+1] <= vert_q[i];
    end
  end

  // angle sum; a zero vector contributes nothing
  logic gt_q;

  always_ff @(posedge clk_i) begin
    logic signed [SumW-1:0] circ;
    circ = '0;
    for (int k = 0; k < 4; k++) begin
      if (!zero_q[CORDIC_STAGES][k]) circ = circ + SumW'(cz_q[CORDIC_STAGES][k]);
    end
    gt_q <= circ > PiFix;
    vert_q[CORDIC_STAGES+1] <= vert_q[CORDIC_STAGES];
  end

  always_ff @(posedge clk_i) begin
    inside_res_o <= gt_q | vert_q[CORDIC_STAGES+1];
    on_vertex_o  <= vert_q[CORDIC_STAGES+1];
    tag_out_o    <= tag_q[NV-2];
  end

  assign done_o = v_q[NV-1];

endmodule

FILE: design/qcpc_checker.sv
`timescale 1ns / 1ps

module qcpc_checker
  import qcpc_pkg::*;
#(
  parameter int LAT = CordicStagesDef + 7
) (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            start_i,
  input logic            busy_o,
  input logic [TagW-1:0] face_id_i,
  input logic            done_o,
  input logic [TagW-1:0] tag_out_o,
  input logic            inside_res_o,
  input logic            on_vertex_o
);

  // a result word only follows an accepted item, with its tag
  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, LAT))
    else $error("result without accepted item");

  a_tag_echo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> tag_out_o == $past(face_id_i, LAT))
    else $error("tag mismatch");

  a_vertex_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && on_vertex_o |-> inside_res_o)
    else $error("vertex point not inside");

  a_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> !busy_o)
    else $error("pipe stalled");

endmodule

bind quad_cell_point_containment_top qcpc_checker #(.LAT(CORDIC_STAGES + 7)) u_qcpc_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o),
  .face_id_i(face_id_i), .done_o(done_o), .tag_out_o(tag_out_o),
  .inside_res_o(inside_res_o), .on_vertex_o(on_vertex_o)
);
